// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define CCL_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("ccl assertion failed");

// checked on every clock edge, reset included
`define CCL_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("ccl assertion failed");

`endif

// ----- rtl/ccl_pkg.sv -----
`timescale 1ns / 1ps

package ccl_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;
   localparam int VALUE_BITS_DEF = 8;

   localparam int STORE_AW    = 16;
   localparam int STORE_DEPTH = 65536;
   localparam int LABEL_W     = 16;
   localparam int DIM_W       = 9;
   localparam int PIX_W       = 8;
   localparam int COUNT_W     = 17;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_READ  = 2'd1,
      OP_FRAME = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_SPARE2 = 2'd2,
      REG_SPARE3 = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      PH_A    = 2'd0,
      PH_B    = 2'd1,
      PH_READ = 2'd2,
      PH_NONE = 2'd3
   } find_phase_type;

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_LN    = 13'b0000000000010,
      S_NCHK  = 13'b0000000000100,
      S_NE    = 13'b0000000001000,
      S_NECHK = 13'b0000000010000,
      S_W     = 13'b0000000100000,
      S_WCHK  = 13'b0000001000000,
      S_PRD   = 13'b0000010000000,
      S_PCHK  = 13'b0000100000000,
      S_LRD   = 13'b0001000000000,
      S_LCHK  = 13'b0010000000000,
      S_RESP  = 13'b0100000000000,
      S_FIN   = 13'b1000000000000
   } state_type;

endpackage

// ----- rtl/ccl_line_buf.sv -----
`timescale 1ns / 1ps

// one row of pixel values and provisional labels, one write and one read port
module ccl_line_buf #(
   parameter int DEPTH = ccl_pkg::MAX_WIDTH_DEF,
   parameter int VW    = ccl_pkg::VALUE_BITS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [VW-1:0]              wr_value,
   input  logic [ccl_pkg::LABEL_W-1:0] wr_label,
   input  logic [AW-1:0]              rd_addr,
   output logic [VW-1:0]              rd_value,
   output logic [ccl_pkg::LABEL_W-1:0] rd_label
);

   logic [VW-1:0]               value_mem [DEPTH];
   logic [ccl_pkg::LABEL_W-1:0] label_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_mem[wr_addr] <= wr_value;
         label_mem[wr_addr] <= wr_label;
      end
      rd_value <= value_mem[rd_addr];
      rd_label <= label_mem[rd_addr];
   end

endmodule

// ----- rtl/connected_component_labeler_top.sv -----
`timescale 1ns / 1ps
// load item: busy through the neighbour checks, plus a walk of both parent chains when it merges
// read item: result after a walk of the parent chain (no walk for an
//   invalid index), ready again as the result appears; waits while the output register is full
// throughput: one item at a time; frame-full loads, new frame and unused opcode finish without leaving idle
// reset (synchronous, active high) clears counters and handshakes and sets width and height to 256;
//   line, label and parent stores are not cleared

`include "assert_macros.svh"

module connected_component_labeler_top #(
   parameter int MAX_WIDTH  = ccl_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = ccl_pkg::MAX_HEIGHT_DEF,
   parameter int VALUE_BITS = ccl_pkg::VALUE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // pixel_value[7:0], pixel_index[23:8]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // final_label[15:0]
   output logic        rsp_tuser,   // index_invalid[0]
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int VB = (VALUE_BITS < ccl_pkg::PIX_W) ? VALUE_BITS : ccl_pkg::PIX_W;
   localparam int LW = ccl_pkg::LABEL_W;
   localparam int NW = ccl_pkg::COUNT_W;
   localparam int DW = ccl_pkg::DIM_W;

   // registers
   logic [DW-1:0] width_ff, height_ff;

   // control state
   ccl_pkg::state_type      state_ff, state_in;
   ccl_pkg::find_phase_type phase_ff, phase_in;
   logic [CW-1:0] col_ff, col_in;
   logic          row_nz_ff, row_nz_in;
   logic [NW-1:0] loaded_ff, loaded_in;
   logic [NW-1:0] next_lab_ff, next_lab_in;
   logic [VB-1:0] nw_val_ff, nw_val_in;
   logic [LW-1:0] nw_lab_ff, nw_lab_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // per-item working registers
   logic [VB-1:0] pix_ff, pix_in;
   logic [LW-1:0] idx_ff, idx_in;
   logic [CW-1:0] x_ff, x_in;
   logic          has_n_ff, has_n_in, has_ne_ff, has_ne_in;
   logic          has_nw_ff, has_nw_in, has_w_ff, has_w_in;
   logic [VB-1:0] n_val_ff, n_val_in;
   logic [LW-1:0] n_lab_ff, n_lab_in;
   logic [LW-1:0] lab_ff, lab_in;
   logic          merge_ff, merge_in;       // west check is for a merge
   logic [LW-1:0] cur_ff, cur_in;           // walker position
   logic [LW-1:0] other_ff, other_in;       // second merge operand
   logic [LW-1:0] root_a_ff, root_a_in;
   logic          pw_en_ff, pw_en_in;
   logic [LW-1:0] pw_addr_ff, pw_addr_in, pw_data_ff, pw_data_in;
   logic [LW-1:0] res_lab_ff, res_lab_in;
   logic          res_inv_ff, res_inv_in;
   logic [LW-1:0] out_lab_ff, out_lab_in;
   logic          out_inv_ff, out_inv_in;

   // stores
   logic [LW-1:0] label_mem  [ccl_pkg::STORE_DEPTH];
   logic [LW-1:0] parent_mem [ccl_pkg::STORE_DEPTH];
   logic [LW-1:0] label_rd_ff, parent_rd_ff;
   logic [LW-1:0] label_raddr, parent_raddr;

   // line buffer port
   logic          lb_wr_en;
   logic [CW-1:0] lb_raddr;
   logic [VB-1:0] lb_rd_value;
   logic [LW-1:0] lb_rd_label;

   // decoded input item
   ccl_pkg::opcode_type req_op;
   logic [VB-1:0] req_pix;
   logic [LW-1:0] req_idx;
   logic          req_fire;
   logic          frame_start;

   // frame geometry
   logic [DW-1:0]    w_eff, h_eff;
   logic [2*DW-1:0]  area;
   logic [NW-1:0]    limit;
   logic [CW-1:0]    x_now;

   assign req_op   = ccl_pkg::opcode_type'(req_tuser);
   assign req_pix  = req_tdata[VB-1:0];
   assign req_idx  = req_tdata[23:8];
   assign req_tready = (state_ff == ccl_pkg::S_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign frame_start = req_fire && (req_op == ccl_pkg::OP_FRAME);
   assign csr_ready = 1'b1;

   // clamp dimensions to 1..max
   always_comb begin
      if (width_ff == '0) w_eff = DW'(1);
      else if (32'(width_ff) > 32'(MAX_WIDTH)) w_eff = DW'(MAX_WIDTH);
      else w_eff = width_ff;
      if (height_ff == '0) h_eff = DW'(1);
      else if (32'(height_ff) > 32'(MAX_HEIGHT)) h_eff = DW'(MAX_HEIGHT);
      else h_eff = height_ff;
      area = (2*DW)'(w_eff) * (2*DW)'(h_eff);
      if (32'(area) > 32'(ccl_pkg::STORE_DEPTH)) limit = NW'(ccl_pkg::STORE_DEPTH);
      else limit = NW'(area);
      // a column at or past the width restarts the row
      if (32'(col_ff) >= 32'(w_eff)) x_now = '0;
      else x_now = col_ff;
   end

   // store read addresses follow the sequencer state
   assign label_raddr  = idx_ff;
   assign parent_raddr = cur_ff;

   always_comb begin
      unique case (state_ff)
         ccl_pkg::S_NE: lb_raddr = CW'(32'(x_ff) + 1);
         ccl_pkg::S_W:  lb_raddr = CW'(32'(x_ff) - 1);
         default:       lb_raddr = x_ff;
      endcase
   end

   assign lb_wr_en = (state_ff == ccl_pkg::S_FIN);

   ccl_line_buf #(
      .DEPTH (MAX_WIDTH),
      .VW    (VB),
      .AW    (CW)
   ) u_line (
      .clock    (clock),
      .wr_en    (lb_wr_en),
      .wr_addr  (x_ff),
      .wr_value (pix_ff),
      .wr_label (lab_ff),
      .rd_addr  (lb_raddr),
      .rd_value (lb_rd_value),
      .rd_label (lb_rd_label)
   );

   always_ff @(posedge clock) begin
      if (state_ff == ccl_pkg::S_FIN) begin
         label_mem[loaded_ff[ccl_pkg::STORE_AW-1:0]] <= lab_ff;
         if (pw_en_ff) begin
            parent_mem[pw_addr_ff] <= pw_data_ff;
         end
      end
      label_rd_ff  <= label_mem[label_raddr];
      parent_rd_ff <= parent_mem[parent_raddr];
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      col_in      = col_ff;
      row_nz_in   = row_nz_ff;
      loaded_in   = loaded_ff;
      next_lab_in = next_lab_ff;
      nw_val_in   = nw_val_ff;
      nw_lab_in   = nw_lab_ff;
      pix_in      = pix_ff;
      idx_in      = idx_ff;
      x_in        = x_ff;
      has_n_in    = has_n_ff;
      has_ne_in   = has_ne_ff;
      has_nw_in   = has_nw_ff;
      has_w_in    = has_w_ff;
      n_val_in    = n_val_ff;
      n_lab_in    = n_lab_ff;
      lab_in      = lab_ff;
      merge_in    = merge_ff;
      cur_in      = cur_ff;
      other_in    = other_ff;
      root_a_in   = root_a_ff;
      pw_en_in    = pw_en_ff;
      pw_addr_in  = pw_addr_ff;
      pw_data_in  = pw_data_ff;
      res_lab_in  = res_lab_ff;
      res_inv_in  = res_inv_ff;
      out_lab_in  = out_lab_ff;
      out_inv_in  = out_inv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ccl_pkg::S_IDLE: begin
            if (req_fire) begin
               unique case (req_op)
                  ccl_pkg::OP_LOAD: begin
                     if (loaded_ff < limit) begin
                        pix_in    = req_pix;
                        x_in      = x_now;
                        has_n_in  = row_nz_ff;
                        has_ne_in = row_nz_ff && (32'(x_now) + 1 < 32'(w_eff));
                        has_nw_in = row_nz_ff && (x_now != '0);
                        has_w_in  = (x_now != '0);
                        pw_en_in  = 1'b0;
                        merge_in  = 1'b0;
                        state_in  = ccl_pkg::S_LN;
                     end
                  end
                  ccl_pkg::OP_READ: begin
                     idx_in = req_idx;
                     if (NW'(req_idx) >= loaded_ff) begin
                        res_lab_in = '0;
                        res_inv_in = 1'b1;
                        state_in   = ccl_pkg::S_RESP;
                     end else begin
                        state_in = ccl_pkg::S_LRD;
                     end
                  end
                  ccl_pkg::OP_FRAME: begin
                     col_in      = '0;
                     row_nz_in   = 1'b0;
                     loaded_in   = '0;
                     next_lab_in = '0;
                     nw_val_in   = '0;
                     nw_lab_in   = '0;
                  end
                  default: ;
               endcase
            end
         end
         ccl_pkg::S_LN: state_in = ccl_pkg::S_NCHK;
         ccl_pkg::S_NCHK: begin
            n_val_in = lb_rd_value;
            n_lab_in = lb_rd_label;
            if (has_n_ff && lb_rd_value == pix_ff) begin
               lab_in   = lb_rd_label;
               state_in = ccl_pkg::S_FIN;
            end else if (has_ne_ff) begin
               state_in = ccl_pkg::S_NE;
            end else if (has_nw_ff && nw_val_ff == pix_ff) begin
               lab_in   = nw_lab_ff;
               state_in = ccl_pkg::S_FIN;
            end else if (has_w_ff) begin
               state_in = ccl_pkg::S_W;
            end else begin
               lab_in      = next_lab_ff[LW-1:0];
               pw_en_in    = 1'b1;
               pw_addr_in  = next_lab_ff[LW-1:0];
               pw_data_in  = next_lab_ff[LW-1:0];
               next_lab_in = next_lab_ff + NW'(1);
               state_in    = ccl_pkg::S_FIN;
            end
         end
         ccl_pkg::S_NE: state_in = ccl_pkg::S_NECHK;
         ccl_pkg::S_NECHK: begin
            if (lb_rd_value == pix_ff) begin
               lab_in = lb_rd_label;
               if (has_nw_ff && nw_val_ff == pix_ff) begin
                  // north-east and north-west both match: merge them
                  cur_in   = lb_rd_label;
                  other_in = nw_lab_ff;
                  phase_in = ccl_pkg::PH_A;
                  state_in = ccl_pkg::S_PRD;
               end else if (has_w_ff) begin
                  merge_in = 1'b1;
                  state_in = ccl_pkg::S_W;
               end else begin
                  state_in = ccl_pkg::S_FIN;
               end
            end else if (has_nw_ff && nw_val_ff == pix_ff) begin
               lab_in   = nw_lab_ff;
               state_in = ccl_pkg::S_FIN;
            end else if (has_w_ff) begin
               state_in = ccl_pkg::S_W;
            end else begin
               lab_in      = next_lab_ff[LW-1:0];
               pw_en_in    = 1'b1;
               pw_addr_in  = next_lab_ff[LW-1:0];
               pw_data_in  = next_lab_ff[LW-1:0];
               next_lab_in = next_lab_ff + NW'(1);
               state_in    = ccl_pkg::S_FIN;
            end
         end
         ccl_pkg::S_W: state_in = ccl_pkg::S_WCHK;
         ccl_pkg::S_WCHK: begin
            if (merge_ff) begin
               if (lb_rd_value == pix_ff) begin
                  // north-east and west match: merge them
                  cur_in   = lab_ff;
                  other_in = lb_rd_label;
                  phase_in = ccl_pkg::PH_A;
                  state_in = ccl_pkg::S_PRD;
               end else begin
                  state_in = ccl_pkg::S_FIN;
               end
            end else if (lb_rd_value == pix_ff) begin
               lab_in   = lb_rd_label;
               state_in = ccl_pkg::S_FIN;
            end else begin
               lab_in      = next_lab_ff[LW-1:0];
               pw_en_in    = 1'b1;
               pw_addr_in  = next_lab_ff[LW-1:0];
               pw_data_in  = next_lab_ff[LW-1:0];
               next_lab_in = next_lab_ff + NW'(1);
               state_in    = ccl_pkg::S_FIN;
            end
         end
         ccl_pkg::S_PRD: state_in = ccl_pkg::S_PCHK;
         ccl_pkg::S_PCHK: begin
            if (parent_rd_ff < cur_ff) begin
               cur_in   = parent_rd_ff;
               state_in = ccl_pkg::S_PRD;
            end else begin
               unique case (phase_ff)
                  ccl_pkg::PH_A: begin
                     root_a_in = cur_ff;
                     cur_in    = other_ff;
                     phase_in  = ccl_pkg::PH_B;
                     state_in  = ccl_pkg::S_PRD;
                  end
                  ccl_pkg::PH_B: begin
                     // larger root points at the smaller one
                     if (root_a_ff < cur_ff) begin
                        pw_en_in   = 1'b1;
                        pw_addr_in = cur_ff;
                        pw_data_in = root_a_ff;
                     end else if (cur_ff < root_a_ff) begin
                        pw_en_in   = 1'b1;
                        pw_addr_in = root_a_ff;
                        pw_data_in = cur_ff;
                     end
                     state_in = ccl_pkg::S_FIN;
                  end
                  default: begin
                     res_lab_in = cur_ff;
                     res_inv_in = 1'b0;
                     state_in   = ccl_pkg::S_RESP;
                  end
               endcase
            end
         end
         ccl_pkg::S_LRD: state_in = ccl_pkg::S_LCHK;
         ccl_pkg::S_LCHK: begin
            cur_in   = label_rd_ff;
            phase_in = ccl_pkg::PH_READ;
            state_in = ccl_pkg::S_PRD;
         end
         ccl_pkg::S_RESP: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_tready) begin
               out_lab_in   = res_lab_ff;
               out_inv_in   = res_inv_ff;
               rsp_valid_in = 1'b1;
               state_in     = ccl_pkg::S_IDLE;
            end
         end
         ccl_pkg::S_FIN: begin
            nw_val_in = n_val_ff;
            nw_lab_in = n_lab_ff;
            loaded_in = loaded_ff + NW'(1);
            if (32'(x_ff) + 1 >= 32'(w_eff)) begin
               col_in    = '0;
               row_nz_in = 1'b1;
            end else begin
               col_in = CW'(32'(x_ff) + 1);
            end
            state_in = ccl_pkg::S_IDLE;
         end
         default: state_in = ccl_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ccl_pkg::S_IDLE;
         phase_ff     <= ccl_pkg::PH_A;
         col_ff       <= '0;
         row_nz_ff    <= 1'b0;
         loaded_ff    <= '0;
         next_lab_ff  <= '0;
         nw_val_ff    <= '0;
         nw_lab_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         pw_en_ff     <= 1'b0;
         merge_ff     <= 1'b0;
         width_ff     <= DW'(256);
         height_ff    <= DW'(256);
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         col_ff       <= col_in;
         row_nz_ff    <= row_nz_in;
         loaded_ff    <= loaded_in;
         next_lab_ff  <= next_lab_in;
         nw_val_ff    <= nw_val_in;
         nw_lab_ff    <= nw_lab_in;
         rsp_valid_ff <= rsp_valid_in;
         pw_en_ff     <= pw_en_in;
         merge_ff     <= merge_in;
         if (csr_valid && csr_ready) begin
            unique case (ccl_pkg::reg_index_type'(csr_index))
               ccl_pkg::REG_WIDTH:  width_ff  <= csr_data;
               ccl_pkg::REG_HEIGHT: height_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pix_ff     <= pix_in;
      idx_ff     <= idx_in;
      x_ff       <= x_in;
      has_n_ff   <= has_n_in;
      has_ne_ff  <= has_ne_in;
      has_nw_ff  <= has_nw_in;
      has_w_ff   <= has_w_in;
      n_val_ff   <= n_val_in;
      n_lab_ff   <= n_lab_in;
      lab_ff     <= lab_in;
      cur_ff     <= cur_in;
      other_ff   <= other_in;
      root_a_ff  <= root_a_in;
      pw_addr_ff <= pw_addr_in;
      pw_data_ff <= pw_data_in;
      res_lab_ff <= res_lab_in;
      res_inv_ff <= res_inv_in;
      out_lab_ff <= out_lab_in;
      out_inv_ff <= out_inv_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = out_lab_ff;
   assign rsp_tuser  = out_inv_ff;

   // an invalid index always reports label zero
   `CCL_ASSERT(a_invalid_zero, (rsp_valid_ff && out_inv_ff) |-> (out_lab_ff == '0))
   // load count only drops on a new frame
   `CCL_ASSERT(a_loaded_mono, !frame_start |=> (loaded_ff >= $past(loaded_ff)))
   // a parent never exceeds its child
   `CCL_ASSERT(a_parent_order, (state_ff == ccl_pkg::S_FIN && pw_en_ff) |-> (pw_data_ff <= pw_addr_ff))

endmodule
